[sv/sto_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sto_pkg;

    // configuration register indexes
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PHASE_STEP = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_AMPLITUDE  = 1'b1;
    localparam int CFG_DATA_W = 32;

    // field widths
    localparam int COUNT_W  = 7;
    localparam int SAMPLE_W = 16;
    localparam int STEP_W   = 32;
    localparam int MAG_W    = 15;

    // pi/2 in Q2.30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // controller to datapath commands
    typedef struct packed {
        logic clear;
        logic issue;
        logic last;
    } t_ctl_cmd;

    // datapath to controller status
    typedef struct packed {
        logic advance;
    } t_ctl_sts;

    // quarter-wave table entry k of a table with 2^qlog2 steps per quarter,
    // taylor series of sin through x^13 in Q2.30, scaled to Q1.15
    function automatic logic [15:0] sine_entry(input int unsigned k,
                                               input int unsigned qlog2);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] e;
        longint      sum;
        x    = (64'(k) * HALF_PI_Q30) >> qlog2;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 6; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            case (n)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                default: term = term / 64'd156;
            endcase
            if ((n % 2) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        e = (64'(sum) * 64'd32767 + 64'd536870912) >> 30;
        if (e > 64'd32767) begin
            e = 64'd32767;
        end
        return e[15:0];
    endfunction

endpackage

`default_nettype wire

[sv/sto_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module sto_ctrl #(
    parameter int MAX_BURST = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_req_valid,
    output logic                            o_req_ready,
    input  wire logic [sto_pkg::COUNT_W-1:0] i_req_count,
    input  wire logic                       i_req_restart,
    input  wire sto_pkg::t_ctl_sts          i_sts,
    output sto_pkg::t_ctl_cmd               o_cmd
);

    localparam int CNT_W = $clog2(MAX_BURST + 1);
    localparam logic [sto_pkg::COUNT_W-1:0] MAX_CNT = sto_pkg::COUNT_W'(MAX_BURST);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic             r_state, n_state;
    logic [CNT_W-1:0] r_left,  n_left;
    logic             w_accept;
    logic [CNT_W-1:0] w_count;

    assign o_req_ready = (r_state == S_IDLE);
    assign w_accept    = i_req_valid && o_req_ready;

    // clamp the requested count to the burst limit
    always_comb begin
        if (i_req_count > MAX_CNT) begin
            w_count = CNT_W'(MAX_BURST);
        end else begin
            w_count = CNT_W'(i_req_count);
        end
    end

    // command outputs
    always_comb begin
        o_cmd.clear = w_accept && i_req_restart;
        o_cmd.issue = (r_state == S_RUN) && i_sts.advance;
        o_cmd.last  = (r_left == CNT_W'(1));
    end

    // burst sequencing
    always_comb begin
        n_state = r_state;
        n_left  = r_left;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (w_count != '0)) begin
                    n_state = S_RUN;
                    n_left  = w_count;
                end
            end
            S_RUN: begin
                if (i_sts.advance) begin
                    n_left = r_left - CNT_W'(1);
                    if (r_left == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
        end
    end

endmodule

`default_nettype wire

[sv/sto_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module sto_datapath #(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [sto_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [sto_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire sto_pkg::t_ctl_cmd               i_cmd,
    output sto_pkg::t_ctl_sts                    o_sts,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [sto_pkg::SAMPLE_W-1:0]         o_out_sample,
    output logic                                 o_out_last
);

    localparam int QLOG2   = TABLE_ADDR_BITS - 2;
    localparam int QUARTER = 1 << QLOG2;
    localparam int ADDR_W  = TABLE_ADDR_BITS - 1;
    localparam logic [ADDR_W-1:0] QTR_ADDR = ADDR_W'(QUARTER);

    // configuration registers
    logic [sto_pkg::STEP_W-1:0]          r_step;
    logic signed [sto_pkg::SAMPLE_W-1:0] r_amp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_amp  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                sto_pkg::CFG_PHASE_STEP: r_step <= i_cfg_data;
                sto_pkg::CFG_AMPLITUDE:  r_amp  <= i_cfg_data[sto_pkg::SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    // the whole pipeline moves when the output register is free or drained
    logic w_en;
    assign w_en          = !o_out_valid || i_out_ready;
    assign o_sts.advance = w_en;

    // phase accumulator and table address
    logic [PHASE_BITS-1:0]      r_phase;
    logic [TABLE_ADDR_BITS-1:0] w_idx;
    logic [QLOG2-1:0]           w_r;
    logic [ADDR_W-1:0]          w_addr;

    assign w_idx  = r_phase[PHASE_BITS-1 -: TABLE_ADDR_BITS];
    assign w_r    = w_idx[QLOG2-1:0];
    assign w_addr = w_idx[QLOG2] ? (QTR_ADDR - ADDR_W'(w_r)) : ADDR_W'(w_r);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_cmd.clear) begin
            r_phase <= '0;
        end else if (i_cmd.issue) begin
            r_phase <= r_phase + PHASE_BITS'(r_step);
        end
    end

    // stage a: table address
    logic              r_a_vld;
    logic [ADDR_W-1:0] r_a_addr;
    logic              r_a_neg;
    logic              r_a_last;

    // stage b: table magnitude
    logic                       r_b_vld;
    logic [sto_pkg::MAG_W-1:0]  r_b_mag;
    logic                       r_b_neg;
    logic                       r_b_last;

    // stage c: product
    logic               r_c_vld;
    logic signed [31:0] r_c_prod;
    logic               r_c_last;

    // quarter-wave table built at elaboration
    logic [sto_pkg::MAG_W-1:0] w_rom [QUARTER+1];

    for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
        assign w_rom[k] = sto_pkg::MAG_W'(sto_pkg::sine_entry(k, QLOG2));
    end

    // signed sine and amplitude product
    logic signed [16:0] w_sine;
    logic signed [32:0] w_prod;

    assign w_sine = r_b_neg ? -signed'({2'b00, r_b_mag}) : signed'({2'b00, r_b_mag});
    assign w_prod = 33'(w_sine) * 33'(r_amp);

    // rounding and saturation
    logic signed [32:0] w_rnd;
    logic signed [17:0] w_q;
    logic [sto_pkg::SAMPLE_W-1:0] w_sat;

    assign w_rnd = 33'(r_c_prod) + 33'sd16384;
    assign w_q   = w_rnd[32:15];

    always_comb begin
        if (w_q > 18'sd32767) begin
            w_sat = 16'h7fff;
        end else if (w_q < -18'sd32768) begin
            w_sat = 16'h8000;
        end else begin
            w_sat = w_q[15:0];
        end
    end

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld     <= 1'b0;
            r_b_vld     <= 1'b0;
            r_c_vld     <= 1'b0;
            o_out_valid <= 1'b0;
        end else if (w_en) begin
            r_a_vld     <= i_cmd.issue;
            r_b_vld     <= r_a_vld;
            r_c_vld     <= r_b_vld;
            o_out_valid <= r_c_vld;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_addr     <= w_addr;
            r_a_neg      <= w_idx[TABLE_ADDR_BITS-1];
            r_a_last     <= i_cmd.last;
            r_b_mag      <= w_rom[r_a_addr];
            r_b_neg      <= r_a_neg;
            r_b_last     <= r_a_last;
            r_c_prod     <= w_prod[31:0];
            r_c_last     <= r_b_last;
            o_out_sample <= w_sat;
            o_out_last   <= r_c_last;
        end
    end

endmodule

`default_nettype wire

[sv/sine_tone_oscillator_top.sv]
// the first sample of a burst is issued once the sequencer enters its run state, then passes
// stages a, b, c and the output register; one sample per cycle through a burst unless the
// output stalls; the sequencer holds the request side not ready until a request is fully issued
// output stalls freeze the four-stage sample pipeline and the sequencer's running burst
// reset: synchronous active-low, clears phase, tuning word, amplitude and control
`timescale 1ns / 1ps
`default_nettype none

module sine_tone_oscillator_top #(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10,
    parameter int MAX_BURST       = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [sto_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [sto_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [7:0]                      s_axis_tdata,  // sample_count[6:0], restart[7]
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [15:0]                          m_axis_tdata,  // sample[15:0]
    output logic                                 m_axis_tlast
);

    sto_pkg::t_ctl_cmd w_cmd;
    sto_pkg::t_ctl_sts w_sts;

    // burst sequencer
    sto_ctrl #(
        .MAX_BURST (MAX_BURST)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (s_axis_tvalid),
        .o_req_ready   (s_axis_tready),
        .i_req_count   (s_axis_tdata[6:0]),
        .i_req_restart (s_axis_tdata[7]),
        .i_sts         (w_sts),
        .o_cmd         (w_cmd)
    );

    // phase accumulator, sine table and scaling
    sto_datapath #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_sample (m_axis_tdata),
        .o_out_last   (m_axis_tlast)
    );

endmodule

`default_nettype wire
